@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

@@ rtl/core/pse_pkg.sv @@
`timescale 1ns / 1ps

package pse_pkg;

    localparam int DATA_W              = 32;
    localparam int NUM_W               = 31;
    localparam int OP_W                = 3;
    localparam int DEPTH_W             = 7;
    localparam int STATUS_W            = 2;
    localparam int STACK_DEPTH_DEFAULT = 64;
    localparam int DIV_CNT_W           = $clog2(DATA_W + 1);

    // token operation codes
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVER    = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic                load_token;
        logic                do_push;
        logic                rd_left;
        logic                exec_alu;
        logic                div_start;
        logic                write_back;
        logic                load_out;
        logic [STATUS_W-1:0] status_code;
    } pse_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sp_full;
        logic            sp_lt2;
        logic            right_zero;
        logic            div_busy;
        logic            div_done;
        logic            out_free;
    } pse_stat_t;

endpackage

@@ rtl/core/pse_divider.sv @@
`timescale 1ns / 1ps

module pse_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pse_pkg::DATA_W-1:0]  dividend,
    input  logic [pse_pkg::DATA_W-1:0]  divisor,
    output logic                        busy,
    output logic                        done,
    output logic [pse_pkg::DATA_W-1:0]  quotient
);
    import pse_pkg::*;

    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    mag_b_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;

    // restoring step, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, mag_b_reg};

    always_comb
    begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= DIV_CNT_W'(DATA_W);
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            quo_reg   <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            mag_b_reg <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_reg   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

@@ rtl/core/pse_datapath.sv @@
`timescale 1ns / 1ps

module pse_datapath #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pse_pkg::pse_cmd_t                  cmd,
    output pse_pkg::pse_stat_t                 stat,
    input  logic [pse_pkg::OP_W-1:0]           operation,
    input  logic [pse_pkg::NUM_W-1:0]          number_value,
    input  logic                               start_new,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [pse_pkg::DATA_W-1:0]  top_value,
    output logic [pse_pkg::DEPTH_W-1:0]        stack_depth,
    output logic [pse_pkg::STATUS_W-1:0]       status
);
    import pse_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam logic [PW-1:0] SP_FULL = PW'(STACK_DEPTH);
    localparam logic [PW-1:0] SP_TWO  = PW'(2);

    logic [DATA_W-1:0]   mem [STACK_DEPTH];

    logic [OP_W-1:0]     op_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [PW-1:0]       sp_reg, sp_next;
    logic [DATA_W-1:0]   top_reg;
    logic [DATA_W-1:0]   left_reg;
    logic [DATA_W-1:0]   res_reg;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   top_out_reg;
    logic [DEPTH_W-1:0]  depth_out_reg;
    logic [STATUS_W-1:0] status_out_reg;

    logic [PW-1:0]       sp_minus2;
    logic [PW+DEPTH_W-1:0] sp_wide;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic                div_busy;
    logic                div_done;
    logic [DATA_W-1:0]   div_quotient;

    assign sp_minus2 = sp_reg - SP_TWO;
    assign sp_wide   = {{DEPTH_W{1'b0}}, sp_reg};

    pse_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (left_reg),
        .divisor  (top_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // stack pointer: clear on start flag, grow on push, shrink on writeback
    always_comb
    begin
        sp_next = sp_reg;
        if (cmd.load_token && start_new)
            sp_next = '0;
        else if (cmd.do_push)
            sp_next = sp_reg + 1'b1;
        else if (cmd.write_back)
            sp_next = sp_reg - 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // memory port: push writes at sp, writeback at sp-2
    assign wr_en   = cmd.do_push || cmd.write_back;
    assign wr_addr = cmd.do_push ? sp_reg[AW-1:0] : sp_minus2[AW-1:0];
    assign wr_data = cmd.do_push ? {1'b0, num_reg} : res_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_left)
            left_reg <= mem[sp_minus2[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_token)
        begin
            op_reg  <= operation;
            num_reg <= number_value;
        end
        if (wr_en)
            top_reg <= wr_data;
        if (cmd.exec_alu)
        begin
            case (op_reg)
                OP_ADD:  res_reg <= left_reg + top_reg;
                OP_SUB:  res_reg <= left_reg - top_reg;
                OP_MUL:  res_reg <= left_reg * top_reg;
                default: res_reg <= res_reg;
            endcase
        end
        else if (div_done)
            res_reg <= div_quotient;
        if (cmd.load_out)
        begin
            top_out_reg    <= (sp_reg != '0) ? top_reg : '0;
            depth_out_reg  <= sp_wide[DEPTH_W-1:0];
            status_out_reg <= cmd.status_code;
        end
    end

    assign stat.op         = op_reg;
    assign stat.sp_full    = (sp_reg >= SP_FULL);
    assign stat.sp_lt2     = (sp_reg < SP_TWO);
    assign stat.right_zero = (top_reg == '0);
    assign stat.div_busy   = div_busy;
    assign stat.div_done   = div_done;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign top_value   = top_out_reg;
    assign stack_depth = depth_out_reg;
    assign status      = status_out_reg;

    `ASSERT_NEVER(a_sp_bound, clk, rst_n, sp_reg > SP_FULL)
    `ASSERT_NEVER(a_one_write, clk, rst_n, cmd.do_push && cmd.write_back)
    `ASSERT_PROP(a_div_nonzero, clk, rst_n, cmd.div_start |-> top_reg != '0)

endmodule

@@ rtl/core/pse_controller.sv @@
`timescale 1ns / 1ps

module pse_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pse_pkg::pse_stat_t  stat,
    output pse_pkg::pse_cmd_t   cmd
);
    import pse_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_DIVIDE,
        ST_WRITE,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] status_code_reg, status_code_next;

    always_comb
    begin
        state_next       = state_reg;
        status_code_next = status_code_reg;
        cmd              = '0;
        cmd.status_code  = status_code_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_token = 1'b1;
                    state_next     = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                status_code_next = ST_OK;
                state_next       = ST_FINISH;
                case (stat.op)
                    OP_PUSH:
                    begin
                        if (stat.sp_full)
                            status_code_next = ST_OVER;
                        else
                            cmd.do_push = 1'b1;
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    begin
                        if (stat.sp_lt2)
                            status_code_next = ST_UNDER;
                        else if (stat.op == OP_DIV && stat.right_zero)
                            status_code_next = ST_DIVZERO;
                        else
                        begin
                            cmd.rd_left = 1'b1;
                            state_next  = ST_READ;
                        end
                    end
                    default:
                    begin
                        // unused code: no stack operation; only the start flag acts
                    end
                endcase
            end
            ST_READ:
            begin
                if (stat.op == OP_DIV)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
                else
                begin
                    cmd.exec_alu = 1'b1;
                    state_next   = ST_WRITE;
                end
            end
            ST_DIVIDE:
            begin
                if (stat.div_done)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.write_back = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            status_code_reg <= ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            status_code_reg <= status_code_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    `ASSERT_PROP(a_accept_then_busy, clk, rst_n, (in_valid && !in_stall) |=> in_stall)
    `ASSERT_PROP(a_load_out_free, clk, rst_n, cmd.load_out |-> stat.out_free)
    `ASSERT_PROP(a_div_runs, clk, rst_n, cmd.div_start |=> stat.div_busy)

endmodule

@@ rtl/core/postfix_stack_evaluator_unit.sv @@
`timescale 1ns / 1ps
// Postfix (RPN) evaluator on a bounded operand stack.
// Input channel (in_valid / in_stall): one token per request: operation
//   (push, add, subtract, multiply, divide), number_value for pushes and
//   start_new, which empties the stack before the token is applied.
// Output channel (out_valid / out_stall): one result per token: top_value
//   (0 when empty), stack_depth and status (ok, divide by zero, underflow,
//   overflow). Faulted tokens leave the stack untouched.
// Timing: tokens are handled one at a time; the next token is accepted once
//   the last one's result has been loaded into the output register. The
//   divide time is set by the bit-serial divider (one quotient bit per
//   cycle); add, subtract and multiply by the stack memory read of the left
//   operand and the write-back of the result.
// Stall: the result sits in an output register; a new token may be taken
//   while it waits, but that token's result holds in the core (and in_stall
//   stays high) until the previous result has been taken.
// Reset: asynchronous, active low; the stack is empty and no result is
//   pending. Stack memory contents are not cleared.
module postfix_stack_evaluator_unit #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pse_pkg::OP_W-1:0]           operation,
    input  logic [pse_pkg::NUM_W-1:0]          number_value,
    input  logic                               start_new,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [pse_pkg::DATA_W-1:0]  top_value,
    output logic [pse_pkg::DEPTH_W-1:0]        stack_depth,
    output logic [pse_pkg::STATUS_W-1:0]       status
);
    import pse_pkg::*;

    // command and status buses between sequencer and datapath
    pse_cmd_t  cmd;
    pse_stat_t stat;

    // sequencer: decode, operand fetch, execute, write-back, result hand-off
    pse_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stack memory, top-of-stack register, ALU, divider, output register
    pse_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .operation    (operation),
        .number_value (number_value),
        .start_new    (start_new),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .top_value    (top_value),
        .stack_depth  (stack_depth),
        .status       (status)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

// Token-level check of the postfix evaluator. Requests are driven from a queue
// at the falling edge; both channels are sampled at the rising edge, where every
// accepted token runs through a behavioral copy of the operand stack and every
// accepted result is compared against the oldest predicted one.
module testbench;
    import pse_pkg::*;

    localparam int STACK_SIZE      = STACK_DEPTH_DEFAULT;
    localparam int OP_CODES        = 1 << OP_W;
    localparam int ITEMS_PER_PHASE = 530;
    localparam int LONG_HOLD       = 300;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES    = 60;
    localparam int STUCK_LIMIT     = 4000;  // cycles with no request taken on either side
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [NUM_W-1:0] num;
        logic             start;
    } token_t;

    typedef struct packed {
        logic [DATA_W-1:0]   top;
        logic [DEPTH_W-1:0]  depth;
        logic [STATUS_W-1:0] st;
    } stack_result_t;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      operation    = OP_PUSH;
    logic [NUM_W-1:0]     number_value = '0;
    logic                 start_new    = 1'b0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]   stack_depth;
    logic [STATUS_W-1:0]  status;

    // token source and predicted results
    token_t        token_queue[$];
    stack_result_t expected_results[$];

    // behavioral copy of the operand stack
    logic [DATA_W-1:0] stack_mem [STACK_SIZE];
    int                stack_ptr = 0;

    // traffic shaping, set per phase by the stimulus process
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int hold_request      = 0;
    int hold_seen         = 0;
    int hold_left         = 0;

    logic token_taken    = 1'b0;
    int   stuck_cycles   = 0;
    int   mismatch_count = 0;
    int   result_count   = 0;

    postfix_stack_evaluator_unit #(
        .STACK_DEPTH(STACK_SIZE)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .number_value(number_value),
        .start_new(start_new),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .top_value(top_value),
        .stack_depth(stack_depth),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Applies one token to the stack copy and returns what the block must report.
    // Faulted tokens (overflow, underflow, zero divisor) leave the stack as it was.
    function automatic stack_result_t evaluate_token(token_t tok);
        stack_result_t     r;
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;
        logic [DATA_W-1:0] mag_l;
        logic [DATA_W-1:0] mag_r;
        logic [DATA_W-1:0] quot;
        logic [DATA_W-1:0] res;
        logic              ok;
        r.st = ST_OK;
        res  = '0;
        ok   = 1'b1;
        if (tok.start)
            stack_ptr = 0;
        if (tok.op == OP_PUSH)
        begin
            if (stack_ptr >= STACK_SIZE)
                r.st = ST_OVER;
            else
            begin
                stack_mem[stack_ptr] = {1'b0, tok.num};
                stack_ptr++;
            end
        end
        else if (tok.op <= OP_DIV)
        begin
            if (stack_ptr < 2)
                r.st = ST_UNDER;
            else
            begin
                right = stack_mem[stack_ptr-1];
                left  = stack_mem[stack_ptr-2];
                case (tok.op)
                    OP_ADD: res = left + right;
                    OP_SUB: res = left - right;
                    OP_MUL: res = left * right;
                    default:
                    begin
                        if (right == '0)
                        begin
                            ok   = 1'b0;
                            r.st = ST_DIVZERO;
                        end
                        else
                        begin
                            // magnitude divide, then sign: truncates toward zero and
                            // lets the most negative value over minus one wrap
                            mag_l = left[DATA_W-1] ? -left : left;
                            mag_r = right[DATA_W-1] ? -right : right;
                            quot  = mag_l / mag_r;
                            res   = (left[DATA_W-1] ^ right[DATA_W-1]) ? -quot : quot;
                        end
                    end
                endcase
                if (ok)
                begin
                    stack_ptr--;
                    stack_mem[stack_ptr-1] = res;
                end
            end
        end
        // unused operation codes fall through: only the start flag acts
        r.top   = (stack_ptr > 0) ? stack_mem[stack_ptr-1] : '0;
        r.depth = stack_ptr[DEPTH_W-1:0];
        return r;
    endfunction

    function automatic logic [NUM_W-1:0] rand_number();
        case ($urandom_range(9))
            0, 1, 2, 3: return NUM_W'($urandom_range(9));
            4:          return '0;
            5:          return '1;
            default:    return NUM_W'($urandom());
        endcase
    endfunction

    task automatic add_token(input logic [OP_W-1:0] op, input logic [NUM_W-1:0] num,
                             input logic start);
        token_t tok;
        tok.op    = op;
        tok.num   = num;
        tok.start = start;
        token_queue.push_back(tok);
    endtask

    // One expression: opens with start_new, mostly well-formed postfix with random
    // content, a little noise. A fill expression pushes past full first.
    task automatic gen_expression(input bit fill);
        int depth;
        int len;
        int roll;
        depth = 1;
        add_token(OP_PUSH, rand_number(), 1'b1);
        if (fill)
        begin
            repeat (STACK_SIZE + $urandom_range(1, 3))
                add_token(OP_PUSH, rand_number(), 1'b0);
            depth = STACK_SIZE;
        end
        len = $urandom_range(3, 40);
        repeat (len)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        add_token(OP_W'($urandom_range(OP_DIV + 1, OP_CODES - 1)),
                                  rand_number(), 1'($urandom_range(1)));
                    end
                    1:
                    begin
                        // operator right after a clear: underflow
                        add_token(OP_W'($urandom_range(OP_ADD, OP_DIV)), rand_number(), 1'b1);
                        depth = 0;
                    end
                    default:
                    begin
                        add_token(OP_PUSH, rand_number(), 1'b1);
                        depth = 1;
                    end
                endcase
            end
            else if (depth < 2 || roll < 50)
            begin
                add_token(OP_PUSH, rand_number(), 1'b0);
                depth++;
            end
            else
            begin
                add_token(OP_W'($urandom_range(OP_ADD, OP_DIV)), rand_number(), 1'b0);
                depth--;
            end
        end
    endtask

    // Driver: a new request goes out when the line is free or the last one was
    // taken; a stalled request keeps its payload.
    always @(negedge clk)
    begin : token_driver
        token_t tok;
        if (rst_n && (!in_valid || token_taken))
        begin
            if (token_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                tok          = token_queue.pop_front();
                in_valid     <= 1'b1;
                operation    <= tok.op;
                number_value <= tok.num;
                start_new    <= tok.start;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_seen != hold_request)
        begin
            hold_seen <= hold_request;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Monitor: predict on accepted tokens, compare on accepted results.
    always @(posedge clk)
    begin : result_monitor
        stack_result_t exp_r;
        token_t        tok;
        logic          in_fire;
        logic          out_fire;
        in_fire     = rst_n && in_valid && !in_stall;
        out_fire    = rst_n && out_valid && !out_stall;
        token_taken <= in_fire;
        if (rst_n)
            stuck_cycles <= (in_fire || out_fire) ? 0 : stuck_cycles + 1;
        if (out_fire)
        begin
            result_count++;
            if (expected_results.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("result %0d: no token outstanding, top %0d depth %0d status %0d",
                             result_count, top_value, stack_depth, status);
                mismatch_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (top_value !== exp_r.top || stack_depth !== exp_r.depth
                    || status !== exp_r.st)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("result %0d: exp %0d %0d %0d, got %0d %0d %0d (top depth status)",
                                 result_count, $signed(exp_r.top), exp_r.depth, exp_r.st,
                                 top_value, stack_depth, status);
                    mismatch_count++;
                end
            end
        end
        if (in_fire)
        begin
            tok.op    = operation;
            tok.num   = number_value;
            tok.start = start_new;
            expected_results.push_back(evaluate_token(tok));
        end
    end

    // Watchdog: nothing moving on either channel for too long.
    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int sender_idle_by_phase[3];
        int receiver_idle_by_phase[3];
        sender_idle_by_phase   = '{18, 72, 0};
        receiver_idle_by_phase = '{72, 18, 0};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            @(posedge clk);
            sender_idle_pct   = sender_idle_by_phase[phase];
            receiver_idle_pct = receiver_idle_by_phase[phase];

            if (phase == 0)
            begin
                // wrap on add, zero divisor, truncation of a negative quotient
                add_token(OP_PUSH, '1, 1'b1);
                add_token(OP_PUSH, '1, 1'b0);
                add_token(OP_ADD, '0, 1'b0);
                add_token(OP_PUSH, '0, 1'b0);
                add_token(OP_DIV, '1, 1'b0);
                add_token(OP_SUB, '0, 1'b0);
                add_token(OP_PUSH, 31'd3, 1'b0);
                add_token(OP_MUL, '0, 1'b0);
                add_token(OP_PUSH, 31'd4, 1'b0);
                add_token(OP_DIV, '0, 1'b0);
                // most negative value over minus one
                add_token(OP_PUSH, 31'h4000_0000, 1'b1);
                add_token(OP_PUSH, 31'd2, 1'b0);
                add_token(OP_MUL, '0, 1'b0);
                add_token(OP_PUSH, '0, 1'b0);
                add_token(OP_PUSH, 31'd1, 1'b0);
                add_token(OP_SUB, '0, 1'b0);
                add_token(OP_DIV, '0, 1'b0);
                // operator after a clear, operator on a single entry
                add_token(OP_ADD, '1, 1'b1);
                add_token(OP_PUSH, 31'd5, 1'b0);
                add_token(OP_SUB, '0, 1'b0);
                // unused codes, with and without a clear
                for (int c = OP_DIV + 1; c < OP_CODES; c++)
                    add_token(OP_W'(c), '1, 1'b0);
                add_token(OP_W'(OP_CODES - 1), '0, 1'b1);
                // full stack and overflow
                gen_expression(1'b1);
            end
            else if (phase == 2)
                hold_request++;     // receiver stops for a while; input backs up

            while (token_queue.size() < ITEMS_PER_PHASE)
                gen_expression($urandom_range(14) == 0);
            while (token_queue.size() != 0)
                @(negedge clk);
        end

        while (in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
